// ===== rtl/core/aeskx_pkg.sv =====
`default_nettype none

package aeskx_pkg;

    localparam int unsigned KxWordW   = 32;
    localparam int unsigned KxRoundW  = 4;
    localparam int unsigned KxWords   = 4;
    localparam logic [KxRoundW-1:0] KxLastRound = 4'd10;

    // Control handed from the sequencer to every word cell.
    typedef struct packed {
        logic load;     // take the cipher key words
        logic advance;  // step to the next round key
    } t_cell_ctrl;

    localparam logic [7:0] Sbox [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return Sbox[b];
    endfunction

    // Round constant used when building round key r+1 from round key r.
    function automatic logic [7:0] rcon(input logic [KxRoundW-1:0] r);
        logic [7:0] c;
        unique case (r)
            4'd0:    c = 8'h01;
            4'd1:    c = 8'h02;
            4'd2:    c = 8'h04;
            4'd3:    c = 8'h08;
            4'd4:    c = 8'h10;
            4'd5:    c = 8'h20;
            4'd6:    c = 8'h40;
            4'd7:    c = 8'h80;
            4'd8:    c = 8'h1b;
            4'd9:    c = 8'h36;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/aeskx_subword.sv =====
`default_nettype none

module aeskx_subword
    import aeskx_pkg::*;
(
    input  wire logic [KxWordW-1:0]  i_word,
    input  wire logic [KxRoundW-1:0] i_round,
    output logic      [KxWordW-1:0]  o_word
);

    logic [KxWordW-1:0] w_rot;

    // Rotate left by one byte, substitute each byte, fold in the round constant.
    assign w_rot  = {i_word[23:0], i_word[31:24]};
    assign o_word = {sbox(w_rot[31:24]) ^ rcon(i_round),
                     sbox(w_rot[23:16]),
                     sbox(w_rot[15:8]),
                     sbox(w_rot[7:0])};

endmodule

`default_nettype wire

// ===== rtl/core/aeskx_word_cell.sv =====
`default_nettype none

module aeskx_word_cell
    import aeskx_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_cell_ctrl         i_ctrl,
    input  wire logic [KxWordW-1:0] i_key_word,
    input  wire logic [KxWordW-1:0] i_prev_word,
    output logic      [KxWordW-1:0] o_word,
    output logic      [KxWordW-1:0] o_next_word
);

    logic [KxWordW-1:0] r_word;
    logic [KxWordW-1:0] n_word;

    // The new word is this cell's old word XOR the neighbour's new word.
    assign o_next_word = r_word ^ i_prev_word;
    assign o_word      = r_word;

    always_comb begin
        priority if (i_ctrl.load) begin
            n_word = i_key_word;
        end else if (i_ctrl.advance) begin
            n_word = o_next_word;
        end else begin
            n_word = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

`default_nettype wire

// ===== rtl/core/aes128_key_expansion.sv =====
`default_nettype none

// Channel   Direction  tdata (low bits first)              tuser          tlast
// s_axis    in         key words zero, one, two, three     -              -
// m_axis    out        round words zero, one, two, three   round number   last round
//
// Each accepted key yields eleven round-key transfers, one per cycle when the
// sink keeps tready high. The chain of four word cells produces one round key
// per step. A new key may be accepted at the edge of the last transfer.
// Reset (synchronous, active low) clears the busy flag and round counter only.
// A stall on m_axis freezes the cells; no result is lost or repeated.

module aes128_key_expansion
    import aeskx_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // key_word_zero [31:0], key_word_one [63:32], key_word_two [95:64],
    // key_word_three [127:96]
    input  wire logic [KxWords*KxWordW-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // round_word_zero [31:0], round_word_one [63:32], round_word_two [95:64],
    // round_word_three [127:96]
    output logic [KxWords*KxWordW-1:0]    m_axis_tdata,
    // round_number [3:0]
    output logic [KxRoundW-1:0]           m_axis_tuser,
    // last_round
    output logic                          m_axis_tlast
);

    logic                r_busy;
    logic                n_busy;
    logic [KxRoundW-1:0] r_round;
    logic [KxRoundW-1:0] n_round;

    logic       w_out_xfer;
    logic       w_in_xfer;
    t_cell_ctrl w_ctrl;

    // The word cells hold the round key on show; chain[k] feeds cell k.
    logic [KxWordW-1:0] w_chain [KxWords+1];
    logic [KxWordW-1:0] w_words [KxWords];

    assign w_out_xfer = m_axis_tvalid && m_axis_tready;
    assign m_axis_tlast = (r_round == KxLastRound);

    // Ready when idle, or when the final round key leaves in this cycle.
    assign s_axis_tready = !r_busy || (w_out_xfer && m_axis_tlast);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_busy;
    assign m_axis_tuser  = r_round;

    assign w_ctrl.load    = w_in_xfer;
    assign w_ctrl.advance = w_out_xfer && !m_axis_tlast;

    always_comb begin
        n_busy  = r_busy;
        n_round = r_round;
        priority if (w_in_xfer) begin
            n_busy  = 1'b1;
            n_round = '0;
        end else if (w_out_xfer) begin
            if (m_axis_tlast) begin
                n_busy = 1'b0;
            end else begin
                n_round = r_round + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= '0;
        end else begin
            r_busy  <= n_busy;
            r_round <= n_round;
        end
    end

    // Head of the chain: the rotated, substituted last word with round constant.
    aeskx_subword u_subword (
        .i_word  (w_words[KxWords-1]),
        .i_round (r_round),
        .o_word  (w_chain[0])
    );

    for (genvar k = 0; k < KxWords; k++) begin : g_cell
        aeskx_word_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_key_word  (s_axis_tdata[k*KxWordW +: KxWordW]),
            .i_prev_word (w_chain[k]),
            .o_word      (w_words[k]),
            .o_next_word (w_chain[k+1])
        );
        assign m_axis_tdata[k*KxWordW +: KxWordW] = w_words[k];
    end

    // A held round key keeps new keys out unless it is the last and leaves in this cycle.
    a_no_accept_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !(m_axis_tready && m_axis_tlast)) |-> !s_axis_tready)
        else $error("key accepted while a run is in progress");

    // A key transfer starts a run at round zero.
    a_run_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (m_axis_tvalid && m_axis_tuser == '0))
        else $error("run did not start at round zero");

    // Each non-final transfer moves on by exactly one round.
    a_round_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
            |=> (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 1'b1))
        else $error("round number did not step by one");

    // A stalled round key keeps its words.
    a_stall_holds_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("round key changed under a stall");

    // The round counter never runs past the final round.
    a_round_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= KxLastRound))
        else $error("round number out of range");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
module tb;
    import aeskx_pkg::*;

    // A stall of this many cycles with no transfer on either side means the block has hung.
    localparam int unsigned StallLimit = 4000;
    // Cycles to let pass once every expected round key has arrived.
    localparam int unsigned TailCycles = 40;

    // Known keys: all zeros, all ones, the two published example keys,
    // alternating bit patterns and lone bits at either end of the key.
    localparam logic [127:0] DirectedKeys [8] = '{
        128'h00000000_00000000_00000000_00000000,
        128'hffffffff_ffffffff_ffffffff_ffffffff,
        128'h09cf4f3c_abf71588_28aed2a6_2b7e1516,
        128'h0c0d0e0f_08090a0b_04050607_00010203,
        128'haaaaaaaa_55555555_aaaaaaaa_55555555,
        128'h55555555_aaaaaaaa_55555555_aaaaaaaa,
        128'h00000000_00000000_00000000_80000000,
        128'h00000001_00000000_00000000_00000000
    };

    // Holds the round keys still owed by the block, oldest first, and works
    // them out from each accepted cipher key.
    class key_schedule_board;
        typedef struct packed {
            logic [KxRoundW-1:0]        round;
            logic [KxWords*KxWordW-1:0] words;
            logic                       last;
        } t_round_key;

        t_round_key  owed_keys [$];
        int unsigned mismatches;
        logic [7:0]  sub_table [256];

        // The substitution table is derived from first principles: the
        // multiplicative inverse in GF(2^8) followed by the affine map.
        function new();
            logic [7:0] inv;
            for (int b = 0; b < 256; b++) begin
                inv = 8'h00;
                if (b != 0) begin
                    inv = 8'h01;
                    repeat (254) inv = gf_mul(inv, 8'(b));
                end
                sub_table[b] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3)
                               ^ rotl8(inv, 4) ^ 8'h63;
            end
            mismatches = 0;
        endfunction

        function logic [7:0] rotl8(logic [7:0] v, int k);
            return (v << k) | (v >> (8 - k));
        endfunction

        function logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
            logic [7:0] p;
            p = 8'h00;
            for (int k = 0; k < 8; k++) begin
                if (b[k]) p ^= a;
                a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            end
            return p;
        endfunction

        function void note_key(logic [KxWords*KxWordW-1:0] key);
            logic [KxWordW-1:0] sched [44];
            logic [KxWordW-1:0] t;
            logic [7:0]         rc;
            t_round_key         rk;
            for (int i = 0; i < 4; i++) sched[i] = key[KxWordW*i +: KxWordW];
            rc = 8'h01;
            for (int i = 4; i < 44; i++) begin
                t = sched[i-1];
                if (i % 4 == 0) begin
                    t = {t[23:0], t[31:24]};
                    t = {sub_table[t[31:24]], sub_table[t[23:16]],
                         sub_table[t[15:8]], sub_table[t[7:0]]};
                    t[31:24] ^= rc;
                    rc = gf_mul(rc, 8'h02);
                end
                sched[i] = sched[i-4] ^ t;
            end
            for (int r = 0; r <= KxLastRound; r++) begin
                rk.round = KxRoundW'(r);
                rk.words = {sched[4*r+3], sched[4*r+2], sched[4*r+1], sched[4*r]};
                rk.last  = (r == KxLastRound);
                owed_keys.push_back(rk);
            end
        endfunction

        function void compare_field(string what, logic [KxWordW-1:0] want,
                                    logic [KxWordW-1:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %h got %h", $time, what, want, got);
                mismatches++;
            end
        endfunction

        function void check_round(logic [KxRoundW-1:0] round,
                                  logic [KxWords*KxWordW-1:0] words, logic last);
            t_round_key want;
            if (owed_keys.size() == 0) begin
                $display("%0t: round key transfer with none expected, expected none got %h %h %b",
                         $time, round, words, last);
                mismatches++;
                return;
            end
            want = owed_keys.pop_front();
            compare_field("round number", KxWordW'(want.round), KxWordW'(round));
            compare_field("round word zero", want.words[31:0], words[31:0]);
            compare_field("round word one", want.words[63:32], words[63:32]);
            compare_field("round word two", want.words[95:64], words[95:64]);
            compare_field("round word three", want.words[127:96], words[127:96]);
            compare_field("last round", KxWordW'(want.last), KxWordW'(last));
        endfunction

        function int unsigned pending();
            return owed_keys.size();
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    // key_word_zero [31:0], key_word_one [63:32], key_word_two [95:64],
    // key_word_three [127:96]
    logic [KxWords*KxWordW-1:0]   s_axis_tdata = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    // round_word_zero [31:0], round_word_one [63:32], round_word_two [95:64],
    // round_word_three [127:96]
    logic [KxWords*KxWordW-1:0]   m_axis_tdata;
    // round_number [3:0]
    logic [KxRoundW-1:0]          m_axis_tuser;
    logic                         m_axis_tlast;

    // Percentages of cycles in which the key source and the round-key sink hold back.
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned stall_cycles = 0;

    key_schedule_board board;

    always #2 i_clk = ~i_clk;

    aes128_key_expansion u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Sink side: every value read here is the one held just before the edge,
    // so the check never depends on the order of processes in the time step.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_round(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog: counts cycles in which no transfer takes place on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= StallLimit) begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offers one key, idling first at the current rate, and returns at the edge
    // where the transfer happens. The key is held steady until then. Only one
    // nonblocking write of tvalid falls in any time step, so a key that follows
    // straight on keeps tvalid high without a glitch.
    task automatic send_key(input logic [KxWords*KxWordW-1:0] key);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_key(key);
    endtask

    // Stops offering keys until every round key owed has been taken.
    task automatic drain_round_keys();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // Random keys: mostly uniform, with a quarter having bytes forced to all
    // zeros or all ones so that the S-box extremes turn up in the schedule often.
    task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                             input int unsigned count);
        logic [KxWords*KxWordW-1:0] key;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) begin
            for (int i = 0; i < KxWords; i++) key[KxWordW*i +: KxWordW] = $urandom;
            if ($urandom_range(3) == 0) begin
                for (int j = 0; j < 16; j++) begin
                    if ($urandom_range(2) == 0) key[8*j +: 8] = $urandom_range(1) ? 8'hff : 8'h00;
                end
            end
            send_key(key);
        end
        drain_round_keys();
    endtask

    initial begin
        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Known keys back to back with the sink always ready, so that each new
        // key meets the edge of the previous key's final round transfer.
        foreach (DirectedKeys[k]) send_key(DirectedKeys[k]);
        drain_round_keys();

        // Source seldom idle with a reluctant sink, then the other way round,
        // then both flat out.
        run_phase(11, 87, 80);
        run_phase(87, 11, 80);
        run_phase(0, 0, 90);

        repeat (TailCycles) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
